>>> rtl/core/twsb_pkg.sv
// Package for the time-window sample buffer core.
// Holds the shared widths, command and register codes, controller states and the command and status structs.
package twsb_pkg;

   localparam int Depth      = 1024;
   localparam int SlotWidth  = $clog2(Depth);
   localparam int CountWidth = SlotWidth + 1;
   localparam int TimeWidth  = 48;
   localparam int ValueWidth = 32;
   localparam int IdxWidth   = 16;
   localparam int ProdWidth  = IdxWidth + CountWidth;

   typedef enum logic [1:0] {
      CMD_APPEND  = 2'd0,
      CMD_CLEAR   = 2'd1,
      CMD_DRAW    = 2'd2,
      CMD_REPRUNE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_WINDOW  = 2'd0,
      REG_MAXPTS  = 2'd1,
      REG_PAUSED  = 2'd2
   } reg_type;

   localparam logic [1:0] STATUS_VALID = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_APPEND,
      ST_PUSH,
      ST_PRUNE_RD,
      ST_PRUNE_CHK,
      ST_DIV,
      ST_DRAW_RD,
      ST_DRAW_WAIT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic rd_newest;
      logic rd_src;
      logic overwrite;
      logic push;
      logic pop;
      logic div_start;
      logic div_step;
      logic capture_point;
      logic set_newest;
   } ctrl_type;

   typedef struct packed {
      cmd_type cmd;
      logic    append_store;
      logic    empty;
      logic    newer;
      logic    same;
      logic    prune_pop;
      logic    div_needed;
      logic    div_done;
      logic    draw_ok;
   } stat_type;

endpackage

>>> rtl/core/time_window_sample_buffer_core.sv
// Top level of the time-window sample buffer core.
// Depends on twsb_pkg, twsb_ctrl and twsb_datapath.
//
// Channel   Direction  Content
// req_      in         tdata: cmd, sample time, value, status, render max, draw index
// rsp_      out        tdata: point ok, time, value, count, recent status, time, value
// csr_      in         index 0 window ticks, 1 point limit, 2 paused
//
// A clear, an unstored sample or a draw with no point goes straight to the response; a sample
// not newer than the newest point is read and compared first; a pushed sample or a reprune
// runs the prune loop, which pops points one at a time, and a decimated draw first runs the
// bit-serial divider. Reset is synchronous.
// A stalled response holds the core; no new request is taken until it leaves.
module time_window_sample_buffer_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[1:0], sample_time[49:2], sample_value[81:50], sample_status[83:82],
   // render_max[99:84], draw_index[115:100], zero fill to 119
   input  logic [119:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // point_ok[0], point_time[48:1], point_value[80:49], point_count[91:81],
   // recent_status[93:92], recent_time[141:94], recent_value[173:142], zero fill to 175
   output logic [175:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [47:0]  csr_data
);
   import twsb_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic     pok;
   logic [TimeWidth-1:0]  pt, lt;
   logic [ValueWidth-1:0] pv, lv;
   logic [CountWidth-1:0] pc;
   logic [1:0]            ls;

   assign csr_ready = 1'b1;

   twsb_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .ctrl(ctrl), .stat(stat)
   );

   twsb_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .in_cmd(req_tdata[1:0]), .in_time(req_tdata[49:2]),
      .in_value(req_tdata[81:50]), .in_status(req_tdata[83:82]),
      .in_render_max(req_tdata[99:84]), .in_draw_index(req_tdata[115:100]),
      .csr_we(csr_valid), .csr_idx(csr_index), .csr_data(csr_data),
      .point_ok(pok), .point_time(pt), .point_value(pv), .point_count(pc),
      .recent_status(ls), .recent_time(lt), .recent_value(lv)
   );

   assign rsp_tdata = {2'b0, lv, lt, ls, pc, pv, pt, pok};

endmodule

>>> rtl/core/twsb_datapath.sv
// Datapath of the time-window sample buffer: ring memory, pointers, divider.
// Depends on twsb_pkg.
module twsb_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  twsb_pkg::ctrl_type                    ctrl,
   output twsb_pkg::stat_type                    stat,
   input  logic [1:0]                            in_cmd,
   input  logic [twsb_pkg::TimeWidth-1:0]        in_time,
   input  logic signed [twsb_pkg::ValueWidth-1:0] in_value,
   input  logic [1:0]                            in_status,
   input  logic [twsb_pkg::IdxWidth-1:0]         in_render_max,
   input  logic [twsb_pkg::IdxWidth-1:0]         in_draw_index,
   input  logic                                  csr_we,
   input  logic [1:0]                            csr_idx,
   input  logic [twsb_pkg::TimeWidth-1:0]        csr_data,
   output logic                                  point_ok,
   output logic [twsb_pkg::TimeWidth-1:0]        point_time,
   output logic signed [twsb_pkg::ValueWidth-1:0] point_value,
   output logic [twsb_pkg::CountWidth-1:0]       point_count,
   output logic [1:0]                            recent_status,
   output logic [twsb_pkg::TimeWidth-1:0]        recent_time,
   output logic signed [twsb_pkg::ValueWidth-1:0] recent_value
);
   import twsb_pkg::*;

   logic [TimeWidth-1:0]  time_mem [Depth];
   logic [ValueWidth-1:0] value_mem [Depth];
   logic [TimeWidth-1:0]  rd_time_ff;
   logic [ValueWidth-1:0] rd_value_ff;
   logic [SlotWidth-1:0]  rd_addr;
   logic [SlotWidth-1:0]  wr_addr;
   logic                  wr_en;
   logic                  wr_time_en;

   logic [TimeWidth-1:0]  window_ff;
   logic [CountWidth-1:0] maxpts_ff;
   logic                  paused_ff;

   cmd_type                 cmd_ff;
   logic [TimeWidth-1:0]    time_ff;
   logic [ValueWidth-1:0]   value_ff;
   logic [1:0]              status_ff;
   logic [IdxWidth-1:0]     m_ff;
   logic [IdxWidth-1:0]     idx_ff;

   logic [SlotWidth-1:0]  oldest_ff, oldest_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [1:0]            lstat_ff;
   logic [TimeWidth-1:0]  ltime_ff;
   logic [ValueWidth-1:0] lvalue_ff;
   logic [TimeWidth-1:0]  newest_ff;

   logic [ProdWidth-1:0]  rem_ff;
   logic [CountWidth-1:0] quo_ff;
   logic [IdxWidth-1:0]   dvs_ff;
   logic [4:0]            dcnt_ff;
   logic [CountWidth-1:0] src_ff;
   logic                  point_ok_ff;
   logic [TimeWidth-1:0]  point_time_ff;
   logic [ValueWidth-1:0] point_value_ff;

   logic [CountWidth-1:0] n_m1;
   logic [SlotWidth-1:0]  newest_slot;
   logic [SlotWidth-1:0]  tail_slot;
   logic [SlotWidth-1:0]  src_slot;
   logic [TimeWidth-1:0]  cutoff;
   logic                  win_on;
   logic                  draw_ok;
   logic                  need_div;
   logic [CountWidth-1:0] direct_src;
   logic [IdxWidth-1:0]   count_wide;

   assign n_m1        = count_ff - CountWidth'(1);
   assign newest_slot = oldest_ff + n_m1[SlotWidth-1:0];
   assign tail_slot   = oldest_ff + count_ff[SlotWidth-1:0];
   assign src_slot    = oldest_ff + src_ff[SlotWidth-1:0];
   assign cutoff      = newest_ff - window_ff;
   assign win_on      = (window_ff != '0) && (newest_ff >= window_ff);
   assign count_wide  = {{(IdxWidth-CountWidth){1'b0}}, count_ff};

   always_comb begin
      draw_ok    = 1'b0;
      need_div   = 1'b0;
      direct_src = '0;
      if (count_ff != '0 && m_ff != '0) begin
         if (count_wide <= m_ff) begin
            draw_ok    = idx_ff < count_wide;
            direct_src = idx_ff[CountWidth-1:0];
         end else if (m_ff == IdxWidth'(1)) begin
            draw_ok = (idx_ff == '0);
         end else if (idx_ff < m_ff) begin
            draw_ok = 1'b1;
            if (idx_ff == m_ff - IdxWidth'(1)) begin
               direct_src = n_m1;
            end else begin
               need_div = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rd_addr = oldest_ff;
      if (ctrl.rd_newest) begin
         rd_addr = newest_slot;
      end else if (ctrl.rd_src) begin
         rd_addr = src_slot;
      end
   end

   assign wr_en      = ctrl.overwrite || ctrl.push;
   assign wr_time_en = ctrl.push;
   assign wr_addr    = ctrl.push ? tail_slot : newest_slot;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_mem[wr_addr] <= value_ff;
      end
      if (wr_time_en) begin
         time_mem[wr_addr] <= time_ff;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      if (ctrl.clear) begin
         oldest_in = '0;
         count_in  = '0;
      end else if (ctrl.push) begin
         if (count_ff == CountWidth'(Depth)) begin
            oldest_in = oldest_ff + SlotWidth'(1);
         end else begin
            count_in = count_ff + CountWidth'(1);
         end
      end else if (ctrl.pop && count_ff != '0) begin
         oldest_in = oldest_ff + SlotWidth'(1);
         count_in  = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= '0;
         maxpts_ff     <= '0;
         paused_ff     <= 1'b0;
         oldest_ff     <= '0;
         count_ff      <= '0;
         lstat_ff      <= '0;
         ltime_ff      <= '0;
         lvalue_ff     <= '0;
         cmd_ff        <= CMD_APPEND;
      end else begin
         if (csr_we) begin
            unique case (reg_type'(csr_idx))
               REG_WINDOW: window_ff <= csr_data;
               REG_MAXPTS: maxpts_ff <= csr_data[CountWidth-1:0];
               REG_PAUSED: paused_ff <= csr_data[0];
               default: ;
            endcase
         end
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         if (ctrl.load) begin
            cmd_ff <= cmd_type'(in_cmd);
            if (cmd_type'(in_cmd) == CMD_APPEND) begin
               lstat_ff <= in_status;
               ltime_ff <= in_time;
               if (in_status == STATUS_VALID && !paused_ff) begin
                  lvalue_ff <= in_value;
               end
            end
         end
         if (ctrl.clear) begin
            lstat_ff  <= '0;
            ltime_ff  <= '0;
            lvalue_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         time_ff        <= in_time;
         value_ff       <= in_value;
         status_ff      <= in_status;
         m_ff           <= in_render_max;
         idx_ff         <= in_draw_index;
         point_ok_ff    <= 1'b0;
         point_time_ff  <= '0;
         point_value_ff <= '0;
         src_ff         <= '0;
      end
      if (ctrl.push) begin
         newest_ff <= time_ff;
      end
      if (ctrl.set_newest) begin
         newest_ff <= rd_time_ff;
      end
      if (ctrl.div_start) begin
         if (need_div) begin
            rem_ff <= {{(ProdWidth-IdxWidth){1'b0}}, idx_ff} *
                      {{(ProdWidth-CountWidth){1'b0}}, n_m1};
            dvs_ff <= m_ff - IdxWidth'(1);
            quo_ff <= '0;
            dcnt_ff <= 5'(CountWidth);
         end else begin
            src_ff <= direct_src;
         end
      end
      if (ctrl.div_step) begin
         dcnt_ff <= dcnt_ff - 5'd1;
         if ({1'b0, rem_ff} >= ({{(CountWidth+1){1'b0}}, dvs_ff} << (dcnt_ff - 5'd1))) begin
            rem_ff <= rem_ff - ProdWidth'({{CountWidth{1'b0}}, dvs_ff} << (dcnt_ff - 5'd1));
            quo_ff <= quo_ff | (CountWidth'(1) << (dcnt_ff - 5'd1));
            src_ff <= quo_ff | (CountWidth'(1) << (dcnt_ff - 5'd1));
         end else begin
            src_ff <= quo_ff;
         end
      end
      if (ctrl.capture_point) begin
         point_ok_ff    <= 1'b1;
         point_time_ff  <= rd_time_ff;
         point_value_ff <= rd_value_ff;
      end
   end

   assign stat.cmd          = cmd_ff;
   assign stat.append_store = (status_ff == STATUS_VALID) && !paused_ff;
   assign stat.empty        = (count_ff == '0);
   assign stat.newer        = time_ff > rd_time_ff;
   assign stat.same         = time_ff == rd_time_ff;
   assign stat.prune_pop    = (count_ff != '0) &&
                              ((win_on && rd_time_ff < cutoff) ||
                               (maxpts_ff != '0 && count_ff > maxpts_ff));
   assign stat.div_needed   = need_div;
   assign stat.div_done     = (dcnt_ff == 5'd0);
   assign stat.draw_ok      = draw_ok;

   assign point_ok      = point_ok_ff;
   assign point_time    = point_time_ff;
   assign point_value   = point_value_ff;
   assign point_count   = count_ff;
   assign recent_status = lstat_ff;
   assign recent_time   = ltime_ff;
   assign recent_value  = lvalue_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CountWidth'(Depth))
      else $error("Stored count exceeds capacity.");
   assert property (@(posedge clock) disable iff (reset)
                    ctrl.clear |=> count_ff == '0 && lstat_ff == '0)
      else $error("Clear did not empty the ring.");
   assert property (@(posedge clock) disable iff (reset)
                    ctrl.pop && !ctrl.push && count_ff != '0 |=> count_ff == $past(count_ff) - 1)
      else $error("Pop did not decrement the count.");

endmodule

>>> rtl/core/twsb_ctrl.sv
// Controller state machine of the time-window sample buffer.
// Depends on twsb_pkg; drives the datapath through ctrl_type commands.
module twsb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output twsb_pkg::ctrl_type ctrl,
   input  twsb_pkg::stat_type stat
);
   import twsb_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctrl       = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = ST_APPEND;
            end
         end
         ST_APPEND: begin
            unique case (stat.cmd)
               CMD_APPEND: begin
                  if (!stat.append_store) begin
                     state_in = ST_RESP;
                  end else begin
                     ctrl.rd_newest = 1'b1;
                     state_in = ST_PUSH;
                  end
               end
               CMD_CLEAR: begin
                  ctrl.clear = 1'b1;
                  state_in   = ST_RESP;
               end
               CMD_REPRUNE: begin
                  if (stat.empty) begin
                     state_in = ST_RESP;
                  end else begin
                     ctrl.rd_newest = 1'b1;
                     state_in = ST_DRAW_WAIT;
                  end
               end
               default: begin
                  ctrl.div_start = 1'b1;
                  state_in = stat.draw_ok ? (stat.div_needed ? ST_DIV : ST_DRAW_RD) : ST_RESP;
               end
            endcase
         end
         ST_DRAW_WAIT: begin
            if (stat.cmd == CMD_DRAW) begin
               ctrl.capture_point = 1'b1;
               state_in = ST_RESP;
            end else begin
               ctrl.set_newest = 1'b1;
               state_in = ST_PRUNE_RD;
            end
         end
         ST_PUSH: begin
            if (!stat.empty && !stat.newer) begin
               ctrl.overwrite = stat.same;
               state_in = ST_RESP;
            end else begin
               ctrl.push = 1'b1;
               state_in = ST_PRUNE_RD;
            end
         end
         ST_PRUNE_RD: begin
            state_in = ST_PRUNE_CHK;
         end
         ST_PRUNE_CHK: begin
            if (stat.prune_pop) begin
               ctrl.pop = 1'b1;
               state_in = ST_PRUNE_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_DRAW_RD;
            end else begin
               ctrl.div_step = 1'b1;
            end
         end
         ST_DRAW_RD: begin
            ctrl.rd_src = 1'b1;
            state_in = ST_DRAW_WAIT;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
